@@ hw/rtl/pcd_pkg.sv @@
// shared types and constants of the peak column decimator
package pcd_pkg;

   localparam int SAMPLE_W         = 16;
   localparam int COLUMN_OUT_W     = 24;
   localparam int LEVEL_W          = 15;
   localparam int SCALE_W          = 32;
   localparam int FRAMES_W         = 11;
   localparam int COUNT_W          = 10;
   localparam int CHCOUNT_W        = 2;
   localparam int CSR_INDEX_W      = 3;
   localparam int CSR_DATA_W       = 32;
   localparam int NUM_LANES        = 2;
   localparam int FRAC_BITS        = 16;
   localparam int PROD_W           = SAMPLE_W + SCALE_W;
   localparam int QUEUE_DEPTH      = 4;
   localparam int MAX_CHANNELS_DEF = 2;
   localparam int COLUMN_BITS_DEF  = 24;

   localparam logic [FRAMES_W-1:0]  FRAMES_MAX     = FRAMES_W'(1024);
   localparam logic [CHCOUNT_W-1:0] CHCOUNT_RESET  = CHCOUNT_W'(1);
   localparam logic [FRAMES_W-1:0]  FRAMES_RESET   = FRAMES_W'(1);
   localparam logic [SCALE_W-1:0]   SCALE_RESET    = SCALE_W'(65536);
   localparam logic [LEVEL_W-1:0]   CLIP_RESET     = LEVEL_W'(32767);

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_CHANNEL_COUNT     = 3'd0,
      REG_MIX_DOWN          = 3'd1,
      REG_FRAMES_PER_COLUMN = 3'd2,
      REG_SCALE_FACTOR      = 3'd3,
      REG_CLIP_LEVEL        = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic [CHCOUNT_W-1:0] channel_count;
      logic                 mix_down;
      logic [FRAMES_W-1:0]  frames_per_column;
   } front_cfg_type;

   typedef struct packed {
      logic [SCALE_W-1:0] scale_factor;
      logic [LEVEL_W-1:0] clip_level;
   } back_cfg_type;

   typedef struct packed {
      logic [NUM_LANES-1:0]               mask;
      logic [NUM_LANES-1:0][SAMPLE_W-1:0] peak;
      logic [COLUMN_OUT_W-1:0]            column;
      logic                               final_flag;
   } event_type;

endpackage

@@ hw/rtl/waveform_peak_column_decimator_top.sv @@
// top level of the peak column decimator: registers and the three stages
//
// req_ carries interleaved 16-bit energy samples, req_last on the final one.
// rsp_ carries one beat per channel per finished display column: channel,
// column index, scaled and clipped level, and rsp_final_res on the last
// beat of the stream. csr_ writes a register; the user must write only while idle, the block does not enforce it.
// One sample is taken every cycle; req_ready drops only when the
// four-entry event queue between the front and back stages is full.
// A result beat passes from the event queue through the multiply register
// and the output register before it is offered; the back stage delivers one
// beat per cycle while the receiver is ready, one beat per channel of a
// column.
// A stalled receiver holds its beat in the output register; the multiply
// stage and the queue keep filling until req_ready drops.
// The block ends the stream after the last sample and starts afresh.
// Reset empties the queue and pipeline, clears the stream state but the
// peak values and loads the register defaults; no clearing sweep is needed.
module waveform_peak_column_decimator_top #(
   parameter int MAX_CHANNELS = pcd_pkg::MAX_CHANNELS_DEF,
   parameter int COLUMN_BITS  = pcd_pkg::COLUMN_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [pcd_pkg::SAMPLE_W-1:0]      req_sample,
   input  logic                              req_last,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic                              rsp_channel,
   output logic [pcd_pkg::COLUMN_OUT_W-1:0]  rsp_column,
   output logic [pcd_pkg::LEVEL_W-1:0]       rsp_level,
   output logic                              rsp_final_res,
   input  logic                              csr_we,
   input  logic [pcd_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [pcd_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   pcd_pkg::front_cfg_type front_cfg_ff, front_cfg_in;
   pcd_pkg::back_cfg_type  back_cfg_ff, back_cfg_in;
   pcd_pkg::event_type     push_data, pop_data;
   logic                   push_valid, push_ready;
   logic                   pop_valid, pop;

   always_comb begin
      front_cfg_in = front_cfg_ff;
      back_cfg_in  = back_cfg_ff;
      if (csr_we) begin
         unique case (pcd_pkg::csr_index_type'(csr_index))
            pcd_pkg::REG_CHANNEL_COUNT: begin
               front_cfg_in.channel_count = csr_wdata[pcd_pkg::CHCOUNT_W-1:0];
            end
            pcd_pkg::REG_MIX_DOWN: begin
               front_cfg_in.mix_down = csr_wdata[0];
            end
            pcd_pkg::REG_FRAMES_PER_COLUMN: begin
               front_cfg_in.frames_per_column = csr_wdata[pcd_pkg::FRAMES_W-1:0];
            end
            pcd_pkg::REG_SCALE_FACTOR: begin
               back_cfg_in.scale_factor = csr_wdata[pcd_pkg::SCALE_W-1:0];
            end
            pcd_pkg::REG_CLIP_LEVEL: begin
               back_cfg_in.clip_level = csr_wdata[pcd_pkg::LEVEL_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_cfg_ff.channel_count     <= pcd_pkg::CHCOUNT_RESET;
         front_cfg_ff.mix_down          <= 1'b0;
         front_cfg_ff.frames_per_column <= pcd_pkg::FRAMES_RESET;
         back_cfg_ff.scale_factor       <= pcd_pkg::SCALE_RESET;
         back_cfg_ff.clip_level         <= pcd_pkg::CLIP_RESET;
      end else begin
         front_cfg_ff <= front_cfg_in;
         back_cfg_ff  <= back_cfg_in;
      end
   end

   pcd_front #(
      .MAX_CHANNELS (MAX_CHANNELS),
      .COLUMN_BITS  (COLUMN_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (front_cfg_ff),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_sample (req_sample),
      .req_last   (req_last),
      .ev_valid   (push_valid),
      .ev_data    (push_data),
      .ev_ready   (push_ready)
   );

   pcd_queue #(
      .DEPTH (pcd_pkg::QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_data  (push_data),
      .push_ready (push_ready),
      .pop_valid  (pop_valid),
      .pop_data   (pop_data),
      .pop        (pop)
   );

   pcd_back u_back (
      .clock         (clock),
      .reset         (reset),
      .cfg           (back_cfg_ff),
      .ev_valid      (pop_valid),
      .ev_data       (pop_data),
      .ev_pop        (pop),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_channel   (rsp_channel),
      .rsp_column    (rsp_column),
      .rsp_level     (rsp_level),
      .rsp_final_res (rsp_final_res)
   );

endmodule

@@ hw/rtl/pcd_queue.sv @@
// short event queue between the front and the back
module pcd_queue #(
   parameter int DEPTH = pcd_pkg::QUEUE_DEPTH
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push_valid,
   input  pcd_pkg::event_type  push_data,
   output logic                push_ready,
   output logic                pop_valid,
   output pcd_pkg::event_type  pop_data,
   input  logic                pop
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   pcd_pkg::event_type data_ff [DEPTH];
   logic [PTR_W-1:0]   wptr_ff, wptr_in;
   logic [PTR_W-1:0]   rptr_ff, rptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_push, do_pop;

   assign push_ready = (count_ff != CNT_W'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = data_ff[rptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop && pop_valid;

   always_comb begin
      wptr_in  = wptr_ff;
      rptr_in  = rptr_ff;
      count_in = count_ff;
      if (do_push) begin
         wptr_in = (wptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rptr_in = (rptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (!do_push && do_pop) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         data_ff[wptr_ff] <= push_data;
      end
   end

endmodule

@@ hw/rtl/pcd_front.sv @@
// front: sample intake, mix-down, running peaks and column events
module pcd_front #(
   parameter int MAX_CHANNELS = pcd_pkg::MAX_CHANNELS_DEF,
   parameter int COLUMN_BITS  = pcd_pkg::COLUMN_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  pcd_pkg::front_cfg_type        cfg,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [pcd_pkg::SAMPLE_W-1:0]  req_sample,
   input  logic                          req_last,
   output logic                          ev_valid,
   output pcd_pkg::event_type            ev_data,
   input  logic                          ev_ready
);

   localparam int SW    = pcd_pkg::SAMPLE_W;
   localparam int FW    = pcd_pkg::FRAMES_W;
   localparam int CW    = pcd_pkg::COUNT_W;
   localparam int NL    = pcd_pkg::NUM_LANES;
   localparam int OW    = pcd_pkg::COLUMN_OUT_W;
   localparam int EXT_W = (COLUMN_BITS > OW) ? COLUMN_BITS : OW;

   logic [NL-1:0][SW-1:0]  peak_ff, peak_in, peak_next;
   logic [NL-1:0]          open_ff, open_in, open_next;
   logic [CW-1:0]          frames_ff, frames_in;
   logic [COLUMN_BITS-1:0] column_ff, column_in;
   logic                   chan_ff, chan_in;
   logic [SW-1:0]          held_ff, held_in;
   logic                   phase_ff, phase_in;

   logic                   accept;
   logic                   two_ch;
   logic [FW-1:0]          eff_frames;
   logic [FW-1:0]          frames_next;
   logic [SW:0]            pair_sum;
   logic [SW-1:0]          value;
   logic                   have;
   logic                   frame_done;
   logic                   column_done;
   logic [EXT_W-1:0]       column_ext;

   assign req_ready   = ev_ready;
   assign accept      = req_valid && ev_ready;
   assign two_ch      = cfg.channel_count[1] && (MAX_CHANNELS >= 2);
   assign frames_next = {1'b0, frames_ff} + FW'(1);
   assign pair_sum    = {1'b0, held_ff} + {1'b0, req_sample};
   assign column_ext  = EXT_W'(column_ff);

   always_comb begin
      if (cfg.frames_per_column == '0) begin
         eff_frames = FW'(1);
      end else if (cfg.frames_per_column > pcd_pkg::FRAMES_MAX) begin
         eff_frames = pcd_pkg::FRAMES_MAX;
      end else begin
         eff_frames = cfg.frames_per_column;
      end
   end

   always_comb begin
      value     = req_sample;
      have      = 1'b1;
      peak_next = peak_ff;
      open_next = open_ff;
      if (cfg.mix_down) begin
         if (!phase_ff) begin
            have = 1'b0;
         end else begin
            value = pair_sum[SW:1];
         end
      end
      if (have) begin
         if (!open_ff[chan_ff] || (value > peak_ff[chan_ff])) begin
            peak_next[chan_ff] = value;
         end
         open_next[chan_ff] = 1'b1;
      end
      frame_done  = have && (!two_ch || chan_ff);
      column_done = frame_done && (frames_next >= eff_frames);
   end

   always_comb begin
      ev_valid           = accept && (column_done || req_last) && (open_next != '0);
      ev_data.mask       = open_next;
      ev_data.peak       = peak_next;
      ev_data.column     = column_ext[OW-1:0];
      ev_data.final_flag = req_last;
   end

   always_comb begin
      peak_in   = peak_ff;
      open_in   = open_ff;
      frames_in = frames_ff;
      column_in = column_ff;
      chan_in   = chan_ff;
      held_in   = held_ff;
      phase_in  = phase_ff;
      if (accept && req_last) begin
         open_in   = '0;
         frames_in = '0;
         column_in = '0;
         chan_in   = 1'b0;
         held_in   = '0;
         phase_in  = 1'b0;
      end else if (accept) begin
         if (cfg.mix_down) begin
            phase_in = !phase_ff;
            if (!phase_ff) begin
               held_in = req_sample;
            end
         end
         peak_in = peak_next;
         open_in = column_done ? '0 : open_next;
         if (frame_done) begin
            chan_in = 1'b0;
         end else if (have) begin
            chan_in = 1'b1;
         end
         if (column_done) begin
            frames_in = '0;
            column_in = column_ff + COLUMN_BITS'(1);
         end else if (frame_done) begin
            frames_in = frames_next[CW-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         open_ff   <= '0;
         frames_ff <= '0;
         column_ff <= '0;
         chan_ff   <= 1'b0;
         held_ff   <= '0;
         phase_ff  <= 1'b0;
      end else begin
         open_ff   <= open_in;
         frames_ff <= frames_in;
         column_ff <= column_in;
         chan_ff   <= chan_in;
         held_ff   <= held_in;
         phase_ff  <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      peak_ff <= peak_in;
   end

endmodule

@@ hw/rtl/pcd_back.sv @@
// back: splits column events into beats, scales and clamps the levels
module pcd_back (
   input  logic                              clock,
   input  logic                              reset,
   input  pcd_pkg::back_cfg_type             cfg,
   input  logic                              ev_valid,
   input  pcd_pkg::event_type                ev_data,
   output logic                              ev_pop,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic                              rsp_channel,
   output logic [pcd_pkg::COLUMN_OUT_W-1:0]  rsp_column,
   output logic [pcd_pkg::LEVEL_W-1:0]       rsp_level,
   output logic                              rsp_final_res
);

   localparam int PW = pcd_pkg::PROD_W;
   localparam int LW = pcd_pkg::LEVEL_W;
   localparam int OW = pcd_pkg::COLUMN_OUT_W;
   localparam int FB = pcd_pkg::FRAC_BITS;
   localparam int SH = PW - FB;

   logic          done0_ff, done0_in;
   logic          m_valid_ff, m_valid_in;
   logic          m_chan_ff;
   logic [OW-1:0] m_column_ff;
   logic          m_final_ff;
   logic [PW-1:0] m_prod_ff, m_prod_in;
   logic          out_valid_ff, out_valid_in;
   logic          out_chan_ff;
   logic [OW-1:0] out_column_ff;
   logic [LW-1:0] out_level_ff, out_level_in;
   logic          out_final_ff;

   logic          pending0, pending1;
   logic          sel_chan;
   logic          last_of_event;
   logic          out_free;
   logic          m_load;
   logic          issue;
   logic [SH-1:0] shifted;

   assign pending0      = ev_data.mask[0] && !done0_ff;
   assign pending1      = ev_data.mask[1];
   assign sel_chan      = !pending0;
   assign last_of_event = !(pending0 && pending1);
   assign out_free      = !out_valid_ff || rsp_ready;
   assign m_load        = !m_valid_ff || out_free;
   assign issue         = ev_valid && m_load;
   assign ev_pop        = issue && last_of_event;
   assign m_prod_in     = ev_data.peak[sel_chan] * cfg.scale_factor;
   assign shifted       = m_prod_ff[PW-1:FB];

   always_comb begin
      done0_in = done0_ff;
      if (issue) begin
         done0_in = !last_of_event;
      end
      m_valid_in   = m_load ? issue : m_valid_ff;
      out_valid_in = out_free ? m_valid_ff : out_valid_ff;
      if (shifted > SH'(cfg.clip_level)) begin
         out_level_in = cfg.clip_level;
      end else begin
         out_level_in = shifted[LW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         done0_ff     <= 1'b0;
         m_valid_ff   <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         done0_ff     <= done0_in;
         m_valid_ff   <= m_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (issue) begin
         m_chan_ff   <= sel_chan;
         m_column_ff <= ev_data.column;
         m_final_ff  <= ev_data.final_flag && last_of_event;
         m_prod_ff   <= m_prod_in;
      end
      if (out_free && m_valid_ff) begin
         out_chan_ff   <= m_chan_ff;
         out_column_ff <= m_column_ff;
         out_level_ff  <= out_level_in;
         out_final_ff  <= m_final_ff;
      end
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_channel   = out_chan_ff;
   assign rsp_column    = out_column_ff;
   assign rsp_level     = out_level_ff;
   assign rsp_final_res = out_final_ff;

endmodule

@@ hw/rtl/pcd_checker.sv @@
// port-level checks of the peak column decimator, bound to the top level
module pcd_checker (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              rsp_valid,
   input  logic                              rsp_ready,
   input  logic                              rsp_channel,
   input  logic [pcd_pkg::COLUMN_OUT_W-1:0]  rsp_column,
   input  logic [pcd_pkg::LEVEL_W-1:0]       rsp_level,
   input  logic                              rsp_final_res,
   input  logic                              csr_we,
   input  logic [pcd_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [pcd_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   logic [pcd_pkg::LEVEL_W-1:0] clip_ff, clip_in;

   always_comb begin
      clip_in = clip_ff;
      if (csr_we && (csr_index == pcd_pkg::REG_CLIP_LEVEL)) begin
         clip_in = csr_wdata[pcd_pkg::LEVEL_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clip_ff <= pcd_pkg::CLIP_RESET;
      end else begin
         clip_ff <= clip_in;
      end
   end

   // stalled beat stays up
   a_rsp_hold_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("rsp_valid dropped while stalled");

   // stalled beat keeps its payload
   a_rsp_hold_data: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_channel) && $stable(rsp_column)
         && $stable(rsp_level) && $stable(rsp_final_res))
      else $error("rsp payload changed while stalled");

   // level never above the programmed clip level
   a_level_clipped: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_level <= clip_ff)
      else $error("rsp_level above clip level");

   // nothing left over from before reset
   a_empty_after_reset: assert property (@(posedge clock)
      !reset && $past(reset) |-> !rsp_valid)
      else $error("result beat right after reset");

endmodule

bind waveform_peak_column_decimator_top pcd_checker u_pcd_checker (.*);

@@ bench/testbench.sv @@
// self-checking bench for the peak column decimator: queued beats and register writes vs a predictor
`timescale 1ns / 100ps

module testbench;
   import pcd_pkg::*;

   localparam int SETTLE_CYCLES = 8;
   localparam int TAIL_CYCLES   = 20;
   localparam int HOLD_CYCLES   = 200;
   localparam int CALM_FROM     = 900;
   localparam int CALM_TO       = 1400;
   localparam int RANDOM_ITEMS  = 850;
   localparam int MAX_REPORTS   = 10;
   localparam longint TIMEOUT_NS = 5_000_000;

   typedef enum logic [1:0] {
      STEP_SAMPLE,
      STEP_CSR,
      STEP_DRAIN,
      STEP_HOLD
   } step_kind_type;

   typedef struct {
      step_kind_type          kind;
      logic [SAMPLE_W-1:0]    sample;
      logic                   last;
      logic [CSR_INDEX_W-1:0] index;
      logic [CSR_DATA_W-1:0]  data;
   } stim_step_type;

   typedef struct packed {
      logic                    channel;
      logic [COLUMN_OUT_W-1:0] column;
      logic [LEVEL_W-1:0]      level;
      logic                    final_res;
   } level_beat_type;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_ready;
   logic [SAMPLE_W-1:0]     req_sample = '0;
   logic                    req_last = 1'b0;
   logic                    rsp_valid;
   logic                    rsp_ready = 1'b0;
   logic                    rsp_channel;
   logic [COLUMN_OUT_W-1:0] rsp_column;
   logic [LEVEL_W-1:0]      rsp_level;
   logic                    rsp_final_res;
   logic                    csr_we = 1'b0;
   logic [CSR_INDEX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0]   csr_wdata = '0;

   stim_step_type  pending_steps[$];
   level_beat_type expected_levels[$];
   int             mismatch_count = 0;
   int             cycle_count = 0;
   int             quiet_cycles = 0;
   int             hold_left = 0;
   int             beats_this_sample;
   logic           req_fired = 1'b0;
   logic           hold_go = 1'b0;
   logic           calm;

   // predictor copy of the registers and the stream state
   logic [CHCOUNT_W-1:0] cf_channels;
   logic                 cf_mix;
   logic [FRAMES_W-1:0]  cf_frames;
   logic [SCALE_W-1:0]   cf_scale;
   logic [LEVEL_W-1:0]   cf_clip;

   logic [SAMPLE_W-1:0]     pk_peak [NUM_LANES];
   logic [FRAMES_W-1:0]     pk_frames;
   logic [COLUMN_OUT_W-1:0] pk_column;
   logic                    pk_chan;
   logic [SAMPLE_W-1:0]     pk_held;
   logic                    pk_pair;
   logic [NUM_LANES-1:0]    pk_open;

   assign calm = (cycle_count >= CALM_FROM) && (cycle_count < CALM_TO);

   waveform_peak_column_decimator_top u_dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_sample    (req_sample),
      .req_last      (req_last),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_channel   (rsp_channel),
      .rsp_column    (rsp_column),
      .rsp_level     (rsp_level),
      .rsp_final_res (rsp_final_res),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #(TIMEOUT_NS);
      $display("** waveform_peak_column_decimator_top: FAILED **");
      $finish;
   end

   function automatic void note_fault(string msg);
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS) $display("%0t: %s", $realtime, msg);
   endfunction

   function automatic logic [LEVEL_W-1:0] scaled_level(logic [SAMPLE_W-1:0] peak);
      logic [PROD_W-1:0] product;
      product = PROD_W'(peak) * PROD_W'(cf_scale);
      product = product >> FRAC_BITS;
      if (product > PROD_W'(cf_clip)) return cf_clip;
      return product[LEVEL_W-1:0];
   endfunction

   task automatic restart_stream();
      for (int c = 0; c < NUM_LANES; c++) pk_peak[c] = '0;
      pk_frames = '0;
      pk_column = '0;
      pk_chan   = 1'b0;
      pk_held   = '0;
      pk_pair   = 1'b0;
      pk_open   = '0;
   endtask

   task automatic emit_open_windows();
      level_beat_type beat;
      for (int c = 0; c < NUM_LANES; c++) begin
         if (pk_open[c]) begin
            beat.channel   = 1'(c);
            beat.column    = pk_column;
            beat.level     = scaled_level(pk_peak[c]);
            beat.final_res = 1'b0;
            expected_levels = {expected_levels, beat};
            beats_this_sample++;
         end
      end
      pk_open = '0;
   endtask

   task automatic predict_levels(logic [SAMPLE_W-1:0] sample, logic last);
      logic [SAMPLE_W:0]   pair_sum;
      logic [SAMPLE_W-1:0] value;
      logic [FRAMES_W-1:0] span;
      logic                have;
      logic                lane;
      int                  lanes;
      have  = 1'b1;
      value = sample;
      beats_this_sample = 0;
      if (cf_mix) begin
         if (!pk_pair) begin
            pk_held = sample;
            pk_pair = 1'b1;
            have    = 1'b0;
         end else begin
            pair_sum = {1'b0, pk_held} + {1'b0, sample};
            value    = pair_sum[SAMPLE_W:1];
            pk_pair  = 1'b0;
         end
      end
      if (have) begin
         lane  = pk_chan;
         lanes = (cf_channels >= 2) ? 2 : 1;
         if (pk_open[lane]) begin
            if (value > pk_peak[lane]) pk_peak[lane] = value;
         end else begin
            pk_peak[lane] = value;
            pk_open[lane] = 1'b1;
         end
         if (int'(lane) + 1 >= lanes) begin
            pk_chan   = 1'b0;
            pk_frames = pk_frames + 1'b1;
            span = (cf_frames == 0) ? FRAMES_W'(1) :
                   (cf_frames > FRAMES_MAX) ? FRAMES_MAX : cf_frames;
            if (pk_frames >= span) begin
               emit_open_windows();
               pk_frames = '0;
               pk_column = pk_column + 1'b1;
            end
         end else begin
            pk_chan = 1'b1;
         end
      end
      if (last) begin
         emit_open_windows();
         if (beats_this_sample > 0) begin
            expected_levels[expected_levels.size() - 1].final_res = 1'b1;
         end
         restart_stream();
      end
   endtask

   task automatic queue_sample(logic [SAMPLE_W-1:0] sample, logic last);
      stim_step_type step;
      step = '{STEP_SAMPLE, sample, last, '0, '0};
      pending_steps = {pending_steps, step};
   endtask

   task automatic queue_marker(step_kind_type kind);
      stim_step_type step;
      step = '{kind, '0, 1'b0, '0, '0};
      pending_steps = {pending_steps, step};
   endtask

   task automatic queue_csr(csr_index_type index, logic [CSR_DATA_W-1:0] data);
      stim_step_type step;
      step = '{STEP_CSR, '0, 1'b0, index, data};
      pending_steps = {pending_steps, step};
   endtask

   task automatic queue_config(int ch, int mix, int frames, logic [31:0] scale, int clip);
      queue_csr(REG_CHANNEL_COUNT, CSR_DATA_W'(ch));
      queue_csr(REG_MIX_DOWN, CSR_DATA_W'(mix));
      queue_csr(REG_FRAMES_PER_COLUMN, CSR_DATA_W'(frames));
      queue_csr(REG_SCALE_FACTOR, scale);
      queue_csr(REG_CLIP_LEVEL, CSR_DATA_W'(clip));
   endtask

   function automatic logic [SAMPLE_W-1:0] pick_sample();
      case ($urandom_range(9))
         0:       return '0;
         1:       return '1;
         default: return SAMPLE_W'($urandom);
      endcase
   endfunction

   // monitor: result checks, prediction of accepted beats, register shadow
   always @(posedge clock) begin : observer
      level_beat_type got;
      level_beat_type want;
      cycle_count++;
      req_fired = 1'b0;
      if (reset) begin
         cf_channels = CHCOUNT_RESET;
         cf_mix      = 1'b0;
         cf_frames   = FRAMES_RESET;
         cf_scale    = SCALE_RESET;
         cf_clip     = CLIP_RESET;
         restart_stream();
         expected_levels.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            got = '{rsp_channel, rsp_column, rsp_level, rsp_final_res};
            if (expected_levels.size() == 0) begin
               note_fault($sformatf("unexpected beat: ch %0d col %0d level %0d final %0b",
                                    got.channel, got.column, got.level, got.final_res));
            end else begin
               want = expected_levels.pop_front();
               if (got !== want)
                  note_fault($sformatf({"mismatch: expected ch %0d col %0d level %0d final %0b,",
                                        " got ch %0d col %0d level %0d final %0b"},
                                       want.channel, want.column, want.level, want.final_res,
                                       got.channel, got.column, got.level, got.final_res));
            end
         end
         if (req_valid && req_ready) begin
            req_fired = 1'b1;
            predict_levels(req_sample, req_last);
         end
         if (csr_we) begin
            case (csr_index)
               REG_CHANNEL_COUNT:     cf_channels = csr_wdata[CHCOUNT_W-1:0];
               REG_MIX_DOWN:          cf_mix      = csr_wdata[0];
               REG_FRAMES_PER_COLUMN: cf_frames   = csr_wdata[FRAMES_W-1:0];
               REG_SCALE_FACTOR:      cf_scale    = csr_wdata[SCALE_W-1:0];
               REG_CLIP_LEVEL:        cf_clip     = csr_wdata[LEVEL_W-1:0];
               default: ;
            endcase
         end
      end
   end

   // driver: samples, register writes and pauses from the pending queue
   always @(negedge clock) begin : sender
      stim_step_type          head;
      logic                   keep;
      logic                   offer;
      logic                   settled;
      logic [SAMPLE_W-1:0]    nxt_sample;
      logic                   nxt_last;
      logic                   nxt_we;
      logic [CSR_INDEX_W-1:0] nxt_index;
      logic [CSR_DATA_W-1:0]  nxt_data;
      logic                   nxt_hold;
      keep       = req_valid && !req_fired;
      offer      = keep;
      settled    = (quiet_cycles >= SETTLE_CYCLES);
      nxt_sample = req_sample;
      nxt_last   = req_last;
      nxt_we     = 1'b0;
      nxt_index  = csr_index;
      nxt_data   = csr_wdata;
      nxt_hold   = 1'b0;
      if (!reset && !keep && pending_steps.size() != 0) begin
         head = pending_steps[0];
         case (head.kind)
            STEP_SAMPLE: begin
               if (calm || hold_left != 0 || $urandom_range(99) >= 28) begin
                  offer      = 1'b1;
                  nxt_sample = head.sample;
                  nxt_last   = head.last;
                  void'(pending_steps.pop_front());
               end
            end
            STEP_CSR: begin
               if (settled) begin
                  nxt_we    = 1'b1;
                  nxt_index = head.index;
                  nxt_data  = head.data;
                  void'(pending_steps.pop_front());
               end
            end
            STEP_DRAIN: begin
               if (settled) void'(pending_steps.pop_front());
            end
            STEP_HOLD: begin
               nxt_hold = 1'b1;
               void'(pending_steps.pop_front());
            end
            default: ;
         endcase
      end
      req_valid  <= offer;
      req_sample <= nxt_sample;
      req_last   <= nxt_last;
      csr_we     <= nxt_we;
      csr_index  <= nxt_index;
      csr_wdata  <= nxt_data;
      hold_go    <= nxt_hold;
      quiet_cycles <= (offer || expected_levels.size() != 0) ? 0 : quiet_cycles + 1;
   end

   // receiver: random stalls plus one long hold-off
   always @(negedge clock) begin : receiver
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_left != 0) begin
         rsp_ready <= 1'b0;
      end else if (calm) begin
         rsp_ready <= 1'b1;
      end else begin
         rsp_ready <= ($urandom_range(99) >= 28);
      end
      if (hold_go) begin
         hold_left <= HOLD_CYCLES;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end
   end

   initial begin : stimulus
      int random_items;
      int streams;
      int len;
      int frames;
      int ch;
      int mix;
      int clip;
      logic [31:0] scale;
      bit hold_queued;

      // defaults, extremes of the sample, clipping
      queue_config(1, 0, 1, 32'h0001_0000, 32767);
      queue_sample(16'h0000, 1'b0);
      queue_sample(16'hFFFF, 1'b0);
      queue_sample(16'h3039, 1'b1);
      // mix-down: lone sample with last, odd count flush
      queue_config(1, 1, 2, 32'h0001_0000, 32767);
      queue_sample(16'd100, 1'b1);
      queue_sample(16'd10, 1'b0);
      queue_sample(16'd20, 1'b0);
      queue_sample(16'd30, 1'b1);
      queue_sample(16'hFFFF, 1'b0);
      queue_sample(16'hFFFF, 1'b0);
      queue_sample(16'hFFFE, 1'b0);
      queue_sample(16'hFFFF, 1'b0);
      queue_sample(16'd1, 1'b1);
      // channel count 3 acts as two, partial flush of both windows
      queue_config(3, 0, 3, 32'hFFFF_FFFF, 1000);
      queue_sample(16'd5, 1'b0);
      queue_sample(16'd6, 1'b0);
      queue_sample(16'd7, 1'b0);
      queue_sample(16'd8, 1'b1);
      // channel count dropped mid-stream with the pointer on channel one
      queue_config(2, 0, 4, 32'h0001_0000, 32767);
      queue_sample(16'd1000, 1'b0);
      queue_csr(REG_CHANNEL_COUNT, CSR_DATA_W'(1));
      queue_sample(16'd2000, 1'b0);
      queue_sample(16'd3000, 1'b1);
      // frames zero acts as one, zero gain
      queue_config(0, 0, 0, 32'h0000_0000, 32767);
      queue_sample(16'hFFFF, 1'b0);
      queue_sample(16'd7, 1'b1);
      queue_marker(STEP_DRAIN);

      random_items = 0;
      hold_queued  = 1'b0;
      while (random_items < RANDOM_ITEMS) begin
         if (!hold_queued && random_items >= 300) begin
            hold_queued = 1'b1;
            queue_config(2, 0, 1, 32'h0001_0000, 32767);
            queue_marker(STEP_HOLD);
            for (int i = 0; i < 80; i++) queue_sample(pick_sample(), i == 79);
            random_items += 80;
         end
         ch  = $urandom_range(3);
         mix = ($urandom_range(2) == 0);
         case ($urandom_range(11))
            0:       frames = 0;
            1:       frames = 1024;
            2:       frames = 2047;
            3, 4:    frames = $urandom_range(40, 9);
            default: frames = $urandom_range(8, 1);
         endcase
         case ($urandom_range(5))
            0:       scale = 32'h0000_0000;
            1:       scale = 32'hFFFF_FFFF;
            2:       scale = 32'h0001_0000;
            3:       scale = $urandom;
            default: scale = $urandom_range(32'h0002_0000, 0);
         endcase
         case ($urandom_range(4))
            0:       clip = 0;
            1, 2:    clip = 32767;
            default: clip = $urandom_range(32767, 0);
         endcase
         queue_config(ch, mix, frames, scale, clip);
         streams = $urandom_range(4, 1);
         repeat (streams) begin
            len = ($urandom_range(9) == 0) ? $urandom_range(120, 60) : $urandom_range(40, 1);
            for (int i = 0; i < len; i++)
               queue_sample(pick_sample(), (i == len - 1) || ($urandom_range(29) == 0));
            random_items += len;
            if ($urandom_range(5) == 0) queue_marker(STEP_DRAIN);
         end
      end

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (pending_steps.size() != 0 || req_valid || expected_levels.size() != 0)
         @(negedge clock);
      repeat (TAIL_CYCLES) @(negedge clock);
      if (mismatch_count == 0) begin
         $display("** waveform_peak_column_decimator_top: PASSED **");
      end else begin
         $display("** waveform_peak_column_decimator_top: FAILED **");
      end
      $finish;
   end

endmodule

@@ waveform_peak_column_decimator_top.f @@
hw/rtl/pcd_pkg.sv
hw/rtl/pcd_queue.sv
hw/rtl/pcd_front.sv
hw/rtl/pcd_back.sv
hw/rtl/waveform_peak_column_decimator_top.sv
hw/rtl/pcd_checker.sv
bench/testbench.sv
